// ===== src/tsnv_pkg.sv =====
// Shared widths, command codes, sentinels and interface structs for the two-set visit cost core.
package tsnv_pkg;

  localparam int unsigned TableDepth = 1024;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned PosW  = 34;
  localparam int unsigned DistW = 36;
  localparam int unsigned GapW  = 36;
  localparam int unsigned SumW  = 38;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Sentinels framing each table: one below every point, one above every point.
  localparam logic signed [GapW-1:0] LowSentinel  = -36'sd10000000000;
  localparam logic signed [GapW-1:0] HighSentinel = 36'sd20000000000;

  // Control from the sequencer to the search unit.
  typedef struct packed {
    logic start;
    logic right;
  } srch_ctrl_t;

  // Status from the search unit back to the sequencer.
  typedef struct packed {
    logic                   done;
    logic signed [GapW-1:0] gap;
  } srch_res_t;

endpackage

// ===== src/tsnv_table.sv =====
// One position table: an append-only memory with a fill count and a registered read port.
module tsnv_table #(
  parameter int unsigned TableDepth = tsnv_pkg::TableDepth,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW  = $clog2(TableDepth + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic                      clear_i,
  input  logic [tsnv_pkg::PosW-1:0] wr_data_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [tsnv_pkg::PosW-1:0] rd_data_o,
  output logic [CntW-1:0]           count_o
);

  logic [tsnv_pkg::PosW-1:0] mem_q [TableDepth];
  logic [tsnv_pkg::PosW-1:0] rd_data_q;
  logic [CntW-1:0]           count_q;
  logic                      full;

  assign full = (count_q >= CntW'(TableDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (wr_en_i && !full) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full) begin
      mem_q[count_q[AddrW-1:0]] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("table fill count exceeds the table depth");

endmodule

// ===== src/tsnv_search.sv =====
// Shared binary search unit: finds the nearest framed entry below or above x and its gap.
module tsnv_search #(
  parameter int unsigned TableDepth = tsnv_pkg::TableDepth,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW  = $clog2(TableDepth + 1),
  localparam int unsigned IdxW  = $clog2(TableDepth + 3)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsnv_pkg::srch_ctrl_t      ctrl_i,
  input  logic [tsnv_pkg::PosW-1:0] x_i,
  input  logic [CntW-1:0]           count_i,
  input  logic [tsnv_pkg::PosW-1:0] rd_data_i,
  output logic [AddrW-1:0]          rd_addr_o,
  output tsnv_pkg::srch_res_t       res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MID  = 4'b0010,
    S_CMP  = 4'b0100,
    S_GAP  = 4'b1000
  } srch_state_e;

  srch_state_e state_q, state_d;
  logic        done_q;

  logic [IdxW-1:0] lo_q, hi_q, mid_q, k_q;
  logic            right_q;
  logic signed [tsnv_pkg::GapW-1:0] gap_q;

  logic [IdxW-1:0]             n_ext, last_idx, mid_c, k_clamp, k_fin, addr_idx;
  logic [tsnv_pkg::PosW:0]     target;
  logic                        ge;
  logic signed [tsnv_pkg::GapW-1:0] entry, x_s, gap_c;

  assign n_ext    = IdxW'(count_i);
  assign last_idx = n_ext + IdxW'(1);
  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);

  // Final index: clamp to the high sentinel, and step back one for the left search.
  assign k_clamp = (lo_q > last_idx) ? last_idx : lo_q;
  assign k_fin   = (!right_q && (k_clamp != '0)) ? (k_clamp - IdxW'(1)) : k_clamp;

  // Framed index k maps to table entry k-1; sentinel indexes read a don't-care address.
  always_comb begin
    if (state_q == S_MID) begin
      addr_idx = (lo_q < hi_q) ? mid_c : k_fin;
    end else begin
      addr_idx = mid_q;
    end
  end
  assign rd_addr_o = AddrW'(addr_idx - IdxW'(1));

  // The left search looks for the first entry at or above x+1.
  assign target = right_q ? {1'b0, x_i} : ({1'b0, x_i} + (tsnv_pkg::PosW + 1)'(1));

  always_comb begin
    if (mid_q == '0) begin
      ge = 1'b0;
    end else if (mid_q > n_ext) begin
      ge = 1'b1;
    end else begin
      ge = (target <= {1'b0, rd_data_i});
    end
  end

  always_comb begin
    if (k_q == '0) begin
      entry = tsnv_pkg::LowSentinel;
    end else if (k_q > n_ext) begin
      entry = tsnv_pkg::HighSentinel;
    end else begin
      entry = $signed(tsnv_pkg::GapW'(rd_data_i));
    end
  end

  assign x_s   = $signed(tsnv_pkg::GapW'(x_i));
  assign gap_c = right_q ? (entry - x_s) : (x_s - entry);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (ctrl_i.start) state_d = S_MID;
      S_MID:  state_d = (lo_q < hi_q) ? S_CMP : S_GAP;
      S_CMP:  state_d = S_MID;
      S_GAP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_GAP);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (ctrl_i.start) begin
          lo_q    <= '0;
          hi_q    <= n_ext + IdxW'(2);
          right_q <= ctrl_i.right;
        end
      end
      S_MID: begin
        if (lo_q < hi_q) begin
          mid_q <= mid_c;
        end else begin
          k_q <= k_fin;
        end
      end
      S_CMP: begin
        if (ge) begin
          hi_q <= mid_q;
        end else begin
          lo_q <= mid_q + IdxW'(1);
        end
      end
      S_GAP: gap_q <= gap_c;
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.gap  = gap_q;

  a_mid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (mid_q >= lo_q) && (mid_q < hi_q))
    else $error("search probe lies outside the live window");

  a_final_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GAP |-> k_q <= last_idx)
    else $error("search result index runs past the high sentinel");

endmodule

// ===== src/tsnv_min.sv =====
// Sequential minimum over the six route costs built from the four gaps.
module tsnv_min (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tsnv_pkg::GapW-1:0]  sl_i,
  input  logic signed [tsnv_pkg::GapW-1:0]  tl_i,
  input  logic signed [tsnv_pkg::GapW-1:0]  sr_i,
  input  logic signed [tsnv_pkg::GapW-1:0]  tr_i,
  output logic                              done_o,
  output logic [tsnv_pkg::DistW-1:0]        dist_o
);

  typedef enum logic [2:0] {
    CAND_MAX_L  = 3'd0,
    CAND_MAX_R  = 3'd1,
    CAND_2SL_TR = 3'd2,
    CAND_2TL_SR = 3'd3,
    CAND_SL_2TR = 3'd4,
    CAND_TL_2SR = 3'd5
  } cand_e;

  localparam int unsigned SumW = tsnv_pkg::SumW;
  localparam int unsigned GapW = tsnv_pkg::GapW;

  cand_e                  idx_q;
  logic                   busy_q, done_q;
  logic signed [SumW-1:0] best_q;

  logic signed [GapW-1:0] op_a, op_b, larger;
  logic                   use_max;
  logic signed [SumW-1:0] cand, twice_a, b_ext;

  always_comb begin
    op_a    = sl_i;
    op_b    = tl_i;
    use_max = 1'b0;
    case (idx_q)
      CAND_MAX_L:  begin op_a = sl_i; op_b = tl_i; use_max = 1'b1; end
      CAND_MAX_R:  begin op_a = sr_i; op_b = tr_i; use_max = 1'b1; end
      CAND_2SL_TR: begin op_a = sl_i; op_b = tr_i; end
      CAND_2TL_SR: begin op_a = tl_i; op_b = sr_i; end
      CAND_SL_2TR: begin op_a = tr_i; op_b = sl_i; end
      CAND_TL_2SR: begin op_a = sr_i; op_b = tl_i; end
      default:     begin op_a = sl_i; op_b = tl_i; end
    endcase
  end

  assign larger  = (op_a > op_b) ? op_a : op_b;
  assign twice_a = $signed({op_a[GapW-1], op_a, 1'b0});
  assign b_ext   = $signed({{(SumW - GapW){op_b[GapW-1]}}, op_b});
  assign cand    = use_max ? $signed({{(SumW - GapW){larger[GapW-1]}}, larger})
                           : (twice_a + b_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= CAND_MAX_L;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= CAND_MAX_L;
      end else if (busy_q) begin
        if (idx_q == CAND_TL_2SR) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= cand_e'(idx_q + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_q <= $signed({1'b0, {(SumW - 1){1'b1}}});
    end else if (busy_q && (cand < best_q)) begin
      best_q <= cand;
    end
  end

  // A negative minimum can only come from out-of-order loads; it reads as zero.
  assign dist_o = best_q[SumW-1] ? '0 : best_q[tsnv_pkg::DistW-1:0];
  assign done_o = done_q;

endmodule

// ===== src/two_set_nearest_visit_cost_core.sv =====
// Top level of the two-set nearest visit cost core: command decode, query sequencer, output beat.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   command_i[1:0], position_i[33:0]
//   output   out        out_valid_o / out_stall_i distance_o[35:0]
//
// Loads and clears finish in the cycle they are accepted; the block is ready again at once.
// A query runs four binary searches (A left, A right, B left, B right) on one shared unit, and
// each probe spans the MID and CMP states since the table read is registered. A search over n
// entries makes at most log2(n+2)+1 probes. The input stays stalled for the whole query, and
// longer while a stalled output beat still holds the output register. Reset clears fill counts
// and control, not tables.
module two_set_nearest_visit_cost_core #(
  parameter int unsigned TableDepth = tsnv_pkg::TableDepth,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW  = $clog2(TableDepth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tsnv_pkg::CmdW-1:0]  command_i,
  input  logic [tsnv_pkg::PosW-1:0]  position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tsnv_pkg::DistW-1:0] distance_o
);

  typedef enum logic [3:0] {
    T_IDLE    = 4'b0001,
    T_SEARCH  = 4'b0010,
    T_COMBINE = 4'b0100,
    T_OUT     = 4'b1000
  } top_state_e;

  // Bit 0 selects the right-hand search, bit 1 selects set B.
  typedef enum logic [1:0] {
    PH_A_LEFT  = 2'd0,
    PH_A_RIGHT = 2'd1,
    PH_B_LEFT  = 2'd2,
    PH_B_RIGHT = 2'd3
  } phase_e;

  top_state_e state_q;
  phase_e     phase_q;

  tsnv_pkg::srch_ctrl_t srch_ctrl_q;
  tsnv_pkg::srch_res_t  srch_res;
  logic                 min_start_q;
  logic                 min_done;
  logic [tsnv_pkg::DistW-1:0] min_dist;

  logic [tsnv_pkg::PosW-1:0]        x_q;
  logic signed [tsnv_pkg::GapW-1:0] gap_q [4];

  logic                       out_valid_q;
  logic [tsnv_pkg::DistW-1:0] dist_q;

  tsnv_pkg::cmd_e             cmd;
  logic                       in_accept, is_query, out_free;
  logic                       wr_a, wr_b, clear_tabs;
  logic [AddrW-1:0]           rd_addr;
  logic [tsnv_pkg::PosW-1:0]  rd_data_a, rd_data_b, rd_data;
  logic [CntW-1:0]            count_a, count_b, count_sel;

  // The block takes a beat only between queries.
  assign in_stall_o = (state_q != T_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cmd        = tsnv_pkg::cmd_e'(command_i);
  assign is_query   = in_accept && (cmd == tsnv_pkg::CMD_QUERY);
  assign wr_a       = in_accept && (cmd == tsnv_pkg::CMD_LOAD_A);
  assign wr_b       = in_accept && (cmd == tsnv_pkg::CMD_LOAD_B);
  assign clear_tabs = in_accept && (cmd == tsnv_pkg::CMD_CLEAR);

  // The output register is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  tsnv_table #(.TableDepth(TableDepth)) u_table_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_a),
    .clear_i   (clear_tabs),
    .wr_data_i (position_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data_a),
    .count_o   (count_a)
  );

  tsnv_table #(.TableDepth(TableDepth)) u_table_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_b),
    .clear_i   (clear_tabs),
    .wr_data_i (position_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data_b),
    .count_o   (count_b)
  );

  // Both tables see the same read address; the phase picks which one the search listens to.
  assign rd_data   = phase_q[1] ? rd_data_b : rd_data_a;
  assign count_sel = phase_q[1] ? count_b : count_a;

  tsnv_search #(.TableDepth(TableDepth)) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (srch_ctrl_q),
    .x_i       (x_q),
    .count_i   (count_sel),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .res_o     (srch_res)
  );

  tsnv_min u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (min_start_q),
    .sl_i    (gap_q[PH_A_LEFT]),
    .tl_i    (gap_q[PH_B_LEFT]),
    .sr_i    (gap_q[PH_A_RIGHT]),
    .tr_i    (gap_q[PH_B_RIGHT]),
    .done_o  (min_done),
    .dist_o  (min_dist)
  );

  // Query sequencer. Search starts are registered so that the phase and the query point have
  // settled before the search unit samples the fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      phase_q     <= PH_A_LEFT;
      srch_ctrl_q <= '0;
      min_start_q <= 1'b0;
    end else begin
      srch_ctrl_q.start <= 1'b0;
      min_start_q       <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (is_query) begin
            state_q           <= T_SEARCH;
            phase_q           <= PH_A_LEFT;
            srch_ctrl_q.start <= 1'b1;
            srch_ctrl_q.right <= 1'b0;
          end
        end
        T_SEARCH: begin
          if (srch_res.done) begin
            if (phase_q == PH_B_RIGHT) begin
              state_q     <= T_COMBINE;
              min_start_q <= 1'b1;
            end else begin
              phase_q           <= phase_e'(phase_q + 2'd1);
              srch_ctrl_q.start <= 1'b1;
              srch_ctrl_q.right <= !phase_q[0];
            end
          end
        end
        T_COMBINE: begin
          if (min_done) begin
            state_q <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      x_q <= position_i;
    end
    if (state_q == T_SEARCH && srch_res.done) begin
      gap_q[phase_q] <= srch_res.gap;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == T_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_OUT && out_free) begin
      dist_q <= min_dist;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

  a_search_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> state_q == T_SEARCH)
    else $error("search unit finished outside a query search");

  a_query_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |=> (state_q == T_SEARCH) && srch_ctrl_q.start && (phase_q == PH_A_LEFT))
    else $error("accepted query did not start the first search");

  a_min_done_in_combine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_done |-> state_q == T_COMBINE)
    else $error("minimum unit finished outside the combine step");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the two-set nearest visit cost core.
`timescale 1ns / 100ps

module tb_top;

  localparam longint      PosMax      = (longint'(1) << tsnv_pkg::PosW) - 1;
  localparam longint      BelowAll    = -64'sd10000000000;
  localparam longint      AboveAll    = 64'sd20000000000;
  localparam int unsigned RandomItems = 530;
  localparam int unsigned SettleTime  = 200;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned LongHold    = 400;

  // Mirrors both tables and keeps the distances still owed by the core, oldest first.
  class visit_cost_scoreboard;
    logic [tsnv_pkg::PosW-1:0]  points_a[tsnv_pkg::TableDepth];
    logic [tsnv_pkg::PosW-1:0]  points_b[tsnv_pkg::TableDepth];
    int unsigned                count_a;
    int unsigned                count_b;
    logic [tsnv_pkg::DistW-1:0] pending_distances[$];
    int unsigned                mismatches;

    function new();
      count_a    = 0;
      count_b    = 0;
      mismatches = 0;
    endfunction

    // Entry k of a table framed by one sentinel below and one above.
    function longint framed_point(bit use_b, int unsigned k);
      int unsigned n;
      n = use_b ? count_b : count_a;
      if (k == 0) return BelowAll;
      if (k > n) return AboveAll;
      return use_b ? longint'(points_b[k-1]) : longint'(points_a[k-1]);
    endfunction

    // Binary search for the first framed index whose entry is not below target.
    function int unsigned first_at_or_above(bit use_b, longint target);
      int unsigned n, lo, hi, mid;
      n  = use_b ? count_b : count_a;
      lo = 0;
      hi = n + 2;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (target <= framed_point(use_b, mid)) hi = mid;
        else lo = mid + 1;
      end
      if (lo > n + 1) lo = n + 1;
      return lo;
    endfunction

    function longint gap_below(bit use_b, longint x);
      int unsigned k;
      k = first_at_or_above(use_b, x + 1);
      if (k > 0) k--;
      return x - framed_point(use_b, k);
    endfunction

    function longint gap_above(bit use_b, longint x);
      return framed_point(use_b, first_at_or_above(use_b, x)) - x;
    endfunction

    // Cheapest walk from x that touches one point of each set.
    function logic [tsnv_pkg::DistW-1:0] predict_visit_cost(longint x);
      longint sl, tl, sr, tr, best;
      sl   = gap_below(1'b0, x);
      tl   = gap_below(1'b1, x);
      sr   = gap_above(1'b0, x);
      tr   = gap_above(1'b1, x);
      best = (sl > tl) ? sl : tl;
      if (((sr > tr) ? sr : tr) < best) best = (sr > tr) ? sr : tr;
      if (2 * sl + tr < best) best = 2 * sl + tr;
      if (2 * tl + sr < best) best = 2 * tl + sr;
      if (sl + 2 * tr < best) best = sl + 2 * tr;
      if (tl + 2 * sr < best) best = tl + 2 * sr;
      if (best < 0) best = 0;
      return best[tsnv_pkg::DistW-1:0];
    endfunction

    function void note_beat(tsnv_pkg::cmd_e cmd, logic [tsnv_pkg::PosW-1:0] pos);
      case (cmd)
        tsnv_pkg::CMD_LOAD_A: begin
          if (count_a < tsnv_pkg::TableDepth) begin
            points_a[count_a] = pos;
            count_a++;
          end
        end
        tsnv_pkg::CMD_LOAD_B: begin
          if (count_b < tsnv_pkg::TableDepth) begin
            points_b[count_b] = pos;
            count_b++;
          end
        end
        tsnv_pkg::CMD_QUERY: begin
          pending_distances.push_back(predict_visit_cost(longint'(pos)));
        end
        default: begin
          count_a = 0;
          count_b = 0;
        end
      endcase
    endfunction

    function void check_distance(logic [tsnv_pkg::DistW-1:0] got);
      logic [tsnv_pkg::DistW-1:0] want;
      if (pending_distances.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected distance beat, expected none, got %0d", $time, got);
      end else begin
        want = pending_distances.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: distance mismatch, expected %0d, got %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [tsnv_pkg::CmdW-1:0]  command_i;
  logic [tsnv_pkg::PosW-1:0]  position_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [tsnv_pkg::DistW-1:0] distance_o;

  visit_cost_scoreboard board = new();

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;

  two_set_nearest_visit_cost_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .distance_o (distance_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a correct run ends far below this bound.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Both handshakes are sampled here, input first, so a query is always on record
  // before any result it could cause.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        board.note_beat(tsnv_pkg::cmd_e'(command_i), position_i);
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        board.check_distance(distance_o);
        results_seen++;
      end
    end
  end

  // Output side: random stall runs, plus two long hold-offs that let the core back up
  // until it stalls its input.
  initial begin
    int unsigned level, len, r, holds_done;
    out_stall_i = 1'b0;
    holds_done  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(99);
      if (holds_done < 2 && results_seen >= ((holds_done == 0) ? 20 : 60)) begin
        holds_done++;
        level = 1;
        len   = LongHold;
      end else if (r < 40) begin
        level = 0;
        len   = $urandom_range(40, 1);
      end else if (r < 80) begin
        level = 1;
        len   = $urandom_range(3, 1);
      end else if (r < 95) begin
        level = 1;
        len   = $urandom_range(12, 4);
      end else begin
        level = 1;
        len   = $urandom_range(60, 20);
      end
      repeat (len) @(negedge clk_i) out_stall_i <= level[0];
    end
  end

  function automatic logic [tsnv_pkg::PosW-1:0] any_position();
    logic [tsnv_pkg::PosW-1:0] p;
    p[tsnv_pkg::PosW-1:32] = 2'($urandom_range(3));
    p[31:0]                = $urandom();
    return p;
  endfunction

  function automatic logic [tsnv_pkg::PosW-1:0] clip_position(longint v);
    if (v < 0) return '0;
    if (v > PosMax) return PosMax[tsnv_pkg::PosW-1:0];
    return v[tsnv_pkg::PosW-1:0];
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run of back-to-back beats.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) burst_left = $urandom_range(60, 20);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned table_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(150, 41);
  endfunction

  // Presents one beat at a falling edge and holds it until a rising edge takes it.
  task automatic send_beat(tsnv_pkg::cmd_e cmd, logic [tsnv_pkg::PosW-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i) in_valid_i <= 1'b0;
  endtask

  task automatic drain_queries();
    release_input();
    while (board.pending_distances.size() != 0) @(posedge clk_i);
  endtask

  // Now and then a load lands out of order on purpose, at a random position.
  task automatic load_point(tsnv_pkg::cmd_e cmd, longint value, ref longint points[$]);
    logic [tsnv_pkg::PosW-1:0] p;
    p = ($urandom_range(99) < 3) ? any_position() : clip_position(value);
    points.push_back(longint'(p));
    send_beat(cmd, p);
  endtask

  // One scenario: usually a clear, mostly ascending loads into both sets with random
  // interleaving, then queries aimed near, between and beyond the points, with a few loads among them.
  task automatic run_scenario();
    longint      spread, cur_a, cur_b, lo_end, hi_end, x;
    longint      points[$];
    int unsigned n_a, n_b, n_q, pick;
    if ($urandom_range(99) < 85) send_beat(tsnv_pkg::CMD_CLEAR, any_position());
    n_a = table_size();
    n_b = table_size();
    case ($urandom_range(3))
      0:       spread = $urandom_range(20, 1);
      1:       spread = $urandom_range(2000, 1);
      2:       spread = $urandom_range(2_000_000, 1);
      default: spread = $urandom_range(8_000_000, 1);
    endcase
    pick = $urandom_range(99);
    if (pick < 15) begin
      cur_a = $urandom_range(3);
    end else if (pick < 30) begin
      cur_a = PosMax - spread * 160;
    end else begin
      cur_a = longint'(any_position()) % (PosMax - 200 * 8_000_000);
    end
    cur_b  = cur_a - 2 * spread + longint'($urandom_range(4 * spread, 0));
    lo_end = ((cur_a < cur_b) ? cur_a : cur_b) - 2 * spread;
    while (n_a + n_b > 0) begin
      if (n_b == 0 || (n_a > 0 && $urandom_range(1) == 1)) begin
        cur_a += longint'($urandom_range(spread, 0));
        load_point(tsnv_pkg::CMD_LOAD_A, cur_a, points);
        n_a--;
      end else begin
        cur_b += longint'($urandom_range(spread, 0));
        load_point(tsnv_pkg::CMD_LOAD_B, cur_b, points);
        n_b--;
      end
    end
    hi_end = ((cur_a > cur_b) ? cur_a : cur_b) + 2 * spread;
    n_q    = $urandom_range(8, 2);
    repeat (n_q) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        cur_a += longint'($urandom_range(spread, 0));
        load_point(tsnv_pkg::CMD_LOAD_A, cur_a, points);
      end else if (pick < 8) begin
        cur_b += longint'($urandom_range(spread, 0));
        load_point(tsnv_pkg::CMD_LOAD_B, cur_b, points);
      end else begin
        if (pick < 45 && points.size() > 0) begin
          x = points[$urandom_range(points.size() - 1)] + longint'($urandom_range(4)) - 2;
        end else if (pick < 85) begin
          x = lo_end + longint'($urandom()) % (hi_end - lo_end + 1);
        end else if (pick < 95) begin
          x = any_position();
        end else begin
          x = ($urandom_range(1) == 1) ? 0 : PosMax;
        end
        send_beat(tsnv_pkg::CMD_QUERY, clip_position(x));
      end
    end
  endtask

  initial begin
    int unsigned random_start;
    bit          paused;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = tsnv_pkg::CMD_LOAD_A;
    position_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats: empty tables, field extremes, exact hits, points between and
    // outside both sets, a clear, a single empty set and out-of-order loads.
    send_beat(tsnv_pkg::CMD_QUERY,  '0);
    send_beat(tsnv_pkg::CMD_QUERY,  '1);
    send_beat(tsnv_pkg::CMD_LOAD_A, '0);
    send_beat(tsnv_pkg::CMD_LOAD_A, 34'd1000);
    send_beat(tsnv_pkg::CMD_LOAD_B, 34'd400);
    send_beat(tsnv_pkg::CMD_LOAD_B, '1);
    send_beat(tsnv_pkg::CMD_QUERY,  '0);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd1000);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd700);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd300);
    send_beat(tsnv_pkg::CMD_QUERY,  '1);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd9000000000);
    send_beat(tsnv_pkg::CMD_CLEAR,  '1);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd500);
    send_beat(tsnv_pkg::CMD_LOAD_A, 34'd50);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd10);
    send_beat(tsnv_pkg::CMD_LOAD_B, 34'd40);
    send_beat(tsnv_pkg::CMD_LOAD_A, 34'd30);
    send_beat(tsnv_pkg::CMD_LOAD_A, 34'd20);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd35);
    send_beat(tsnv_pkg::CMD_QUERY,  34'd45);
    send_beat(tsnv_pkg::CMD_CLEAR,  '0);
    drain_queries();

    // Random scenarios, with one pause halfway until every distance is back.
    random_start = items_sent;
    paused       = 1'b0;
    while (items_sent - random_start < RandomItems) begin
      run_scenario();
      if (!paused && items_sent - random_start >= RandomItems / 2) begin
        drain_queries();
        paused = 1'b1;
      end
    end

    drain_queries();
    repeat (SettleTime) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
